@@ design/pli_pkg.sv @@
// Shared types and constants for the piecewise linear table interpolator.
// Used by pli_interp and piecewise_linear_table_interpolator; depends on nothing.
package pli_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_ADC_BITS = 12;

	localparam int PIU_W = 7;
	localparam int IDX_W = 6;
	localparam int TEMP_W = 16;
	localparam int STATUS_W = 2;

	localparam logic CMD_CONVERT = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_INSIDE = 2'd0,
		STATUS_BELOW = 2'd1,
		STATUS_ABOVE = 2'd2
	} range_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_LO,
		S_INIT_HI,
		S_CHECK,
		S_STEP_DN,
		S_STEP_UP,
		S_INTERP,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		IS_IDLE,
		IS_MUL,
		IS_DIV,
		IS_FIN
	} interp_state_t;

endpackage

@@ design/pli_interp.sv @@
// Linear interpolation unit: one signed multiply, then a restoring divider
// that retires one quotient bit per cycle. Depends on pli_pkg.
module pli_interp import pli_pkg::*; #(
	parameter int ADC_BITS = DEF_ADC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ADC_BITS-1:0]      dx,
	input  logic signed [TEMP_W:0]   dy,
	input  logic [ADC_BITS-1:0]      den,
	input  logic signed [TEMP_W-1:0] y0,
	output logic                     done,
	output logic [TEMP_W-1:0]        result
);

	localparam int PROD_W = ADC_BITS + TEMP_W + 2;
	localparam int MAG_W = ADC_BITS + TEMP_W;
	localparam int CNT_W = $clog2(MAG_W + 1);

	interp_state_t state_q, state_d;

	logic [ADC_BITS-1:0]      dx_q;
	logic signed [TEMP_W:0]   dy_q;
	logic [ADC_BITS-1:0]      den_q;
	logic signed [TEMP_W-1:0] y0_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         quo_q;
	logic [ADC_BITS-1:0]      rem_q;
	logic [CNT_W-1:0]         cnt_q;

	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        prod_abs;
	logic [ADC_BITS:0]        shifted;
	logic [ADC_BITS:0]        trial;
	logic                     fits;
	logic signed [TEMP_W:0]   quo_s;
	logic signed [TEMP_W:0]   sum;

	assign prod = $signed({1'b0, dx_q}) * dy_q;
	assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign trial = shifted - {1'b0, den_q};
	assign fits = shifted >= {1'b0, den_q};
	assign quo_s = $signed({1'b0, quo_q[TEMP_W-1:0]});
	assign sum = {y0_q[TEMP_W-1], y0_q} + (neg_q ? -quo_s : quo_s);
	assign result = sum[TEMP_W-1:0];
	assign done = (state_q == IS_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IS_IDLE: begin
				if (start) begin
					state_d = IS_MUL;
				end
			end
			IS_MUL: state_d = IS_DIV;
			IS_DIV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = IS_FIN;
				end
			end
			IS_FIN: state_d = IS_IDLE;
			default: state_d = IS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IS_IDLE: begin
				if (start) begin
					dx_q <= dx;
					dy_q <= dy;
					den_q <= den;
					y0_q <= y0;
				end
			end
			IS_MUL: begin
				neg_q <= prod[PROD_W-1];
				quo_q <= prod_abs[MAG_W-1:0];
				rem_q <= '0;
				cnt_q <= CNT_W'(MAG_W);
			end
			IS_DIV: begin
				rem_q <= fits ? trial[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
				quo_q <= {quo_q[MAG_W-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/piecewise_linear_table_interpolator.sv @@
// Top level of the piecewise linear table interpolator: point memory, segment
// walk sequencer and output register. Depends on pli_pkg and pli_interp.
//
//   channel   direction   handshake             payload
//   in        request in  in_valid / in_stall   cmd, point_index, adc_value, point_temperature
//   out       result out  out_valid / out_stall temperature, range_status
//   cfg       write in    cfg_valid / cfg_ready points_in_use
//
// A load request writes the point memory without leaving the idle state. A
// conversion walks the table from the cached segment, and an interpolated result
// also passes through the multiply and the one-bit-per-cycle divider; the single
// read port of the point memory paces the walk. Reset clears the cached segment
// and sets the point count to two; the point memory is not cleared. A stalled
// output holds the finished result while the next request is already taken.
module piecewise_linear_table_interpolator import pli_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int ADC_BITS = DEF_ADC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic [IDX_W-1:0]         point_index,
	input  logic [ADC_BITS-1:0]      adc_value,
	input  logic signed [TEMP_W-1:0] point_temperature,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TEMP_W-1:0] temperature,
	output logic [STATUS_W-1:0]      range_status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [PIU_W-1:0]         points_in_use
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int DW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = (DW > PIU_W) ? DW : PIU_W;
	localparam int MW = ADC_BITS + TEMP_W;

	ctrl_state_t state_q, state_d;

	logic [MW-1:0] mem [TABLE_DEPTH];
	logic [MW-1:0] rd_data_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [CW-1:0] wr_idx;

	logic [PIU_W-1:0] points_q;
	logic [IW-1:0]    seg_q;
	logic [IW-1:0]    lo_q;
	logic [IW-1:0]    hi_q;
	logic [IW-1:0]    last_q;

	logic [ADC_BITS-1:0]      x_q;
	logic [ADC_BITS-1:0]      x0_q;
	logic [ADC_BITS-1:0]      x1_q;
	logic signed [TEMP_W-1:0] y0_q;
	logic signed [TEMP_W-1:0] y1_q;
	logic signed [TEMP_W-1:0] res_q;
	range_status_t            status_q;

	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] out_temp_q;
	range_status_t            out_status_q;

	logic [CW-1:0]            piu;
	logic [CW-1:0]            n_act;
	logic [CW-1:0]            seg_ext;
	logic [CW-1:0]            lo_init;
	logic [ADC_BITS-1:0]      rd_x;
	logic signed [TEMP_W-1:0] rd_y;
	logic                     accept;
	logic                     out_free;
	logic                     go_below;
	logic                     go_above;
	logic                     step_dn;
	logic                     step_up;
	logic                     hit_hi;
	logic                     hit_lo;
	logic                     interp_start;
	logic                     interp_done;
	logic [TEMP_W-1:0]        interp_result;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	assign piu = CW'(points_q);
	assign n_act = (piu < CW'(2)) ? CW'(2) :
		(piu > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : piu;
	assign seg_ext = CW'(seg_q);
	assign lo_init = (seg_ext > n_act - CW'(2)) ? n_act - CW'(2) : seg_ext;

	assign wr_idx = CW'(point_index);
	assign wr_en = accept && (cmd == CMD_LOAD) && (wr_idx < CW'(TABLE_DEPTH));

	assign rd_x = rd_data_q[MW-1:TEMP_W];
	assign rd_y = $signed(rd_data_q[TEMP_W-1:0]);

	assign go_below = (x0_q > x_q) && (lo_q == '0);
	assign step_dn = (x0_q > x_q) && (lo_q != '0);
	assign go_above = !(x0_q > x_q) && (x1_q < x_q) && (hi_q == last_q);
	assign step_up = !(x0_q > x_q) && (x1_q < x_q) && (hi_q != last_q);
	assign hit_hi = !(x0_q > x_q) && !(x1_q < x_q) && (x_q == x1_q);
	assign hit_lo = !(x0_q > x_q) && !(x1_q < x_q) && (x_q != x1_q) && (x_q == x0_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[IW-1:0]] <= {adc_value, point_temperature};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = lo_q;
		interp_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_CONVERT)) begin
					rd_en = 1'b1;
					rd_addr = lo_init[IW-1:0];
					state_d = S_INIT_LO;
				end
			end
			S_INIT_LO: begin
				rd_en = 1'b1;
				rd_addr = hi_q;
				state_d = S_INIT_HI;
			end
			S_INIT_HI: state_d = S_CHECK;
			S_CHECK: begin
				if (step_dn) begin
					rd_en = 1'b1;
					rd_addr = lo_q - IW'(1);
					state_d = S_STEP_DN;
				end else if (step_up) begin
					rd_en = 1'b1;
					rd_addr = hi_q + IW'(1);
					state_d = S_STEP_UP;
				end else if (go_below || go_above || hit_hi || hit_lo) begin
					state_d = S_DONE;
				end else begin
					interp_start = 1'b1;
					state_d = S_INTERP;
				end
			end
			S_STEP_DN: state_d = S_CHECK;
			S_STEP_UP: state_d = S_CHECK;
			S_INTERP: begin
				if (interp_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && (cmd == CMD_CONVERT)) begin
					x_q <= adc_value;
					lo_q <= lo_init[IW-1:0];
					hi_q <= lo_init[IW-1:0] + IW'(1);
					last_q <= IW'(n_act - CW'(1));
				end
			end
			S_INIT_LO: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
			end
			S_INIT_HI, S_STEP_UP: begin
				x1_q <= rd_x;
				y1_q <= rd_y;
			end
			S_STEP_DN: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
			end
			S_CHECK: begin
				status_q <= go_below ? STATUS_BELOW : go_above ? STATUS_ABOVE : STATUS_INSIDE;
				res_q <= (go_below || hit_lo) ? y0_q : y1_q;
				if (step_dn) begin
					lo_q <= lo_q - IW'(1);
					hi_q <= hi_q - IW'(1);
					x1_q <= x0_q;
					y1_q <= y0_q;
				end else if (step_up) begin
					lo_q <= lo_q + IW'(1);
					hi_q <= hi_q + IW'(1);
					x0_q <= x1_q;
					y0_q <= y1_q;
				end
			end
			S_INTERP: begin
				if (interp_done) begin
					res_q <= $signed(interp_result);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= PIU_W'(2);
			seg_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				points_q <= points_in_use;
			end
			if (state_q == S_DONE && out_free) begin
				seg_q <= lo_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_temp_q <= res_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign temperature = out_temp_q;
	assign range_status = out_status_q;

	pli_interp #(
		.ADC_BITS(ADC_BITS)
	) u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.start(interp_start),
		.dx(x_q - x0_q),
		.dy({y1_q[TEMP_W-1], y1_q} - {y0_q[TEMP_W-1], y0_q}),
		.den(x1_q - x0_q),
		.y0(y0_q),
		.done(interp_done),
		.result(interp_result)
	);

endmodule

@@ dv/tb_piecewise_linear_table_interpolator.sv @@
// Self-checking testbench for the piecewise linear table interpolator: directed rows,
// then random table loads and conversions checked against an in-bench predictor.
// Depends on pli_pkg and the piecewise_linear_table_interpolator RTL.
module tb_piecewise_linear_table_interpolator import pli_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADC_W = DEF_ADC_BITS;
	localparam int DEPTH = DEF_TABLE_DEPTH;
	localparam int ADC_MAX = (1 << ADC_W) - 1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 550;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		range_status_t            status;
	} conversion_t;

	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_CONVERT,
		ROW_POINT_COUNT
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [IDX_W-1:0]         idx;
		logic [ADC_W-1:0]         reading;
		logic signed [TEMP_W-1:0] temp;
		logic [PIU_W-1:0]         count;
		logic                     known;
		logic signed [TEMP_W-1:0] exp_temp;
		range_status_t            exp_status;
	} directed_row_t;

	localparam directed_row_t DIRECTED_ROWS [20] = '{
		'{ROW_LOAD,        6'd0, 12'd100,  16'sh8000, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_LOAD,        6'd1, 12'd4000, 16'sh7FFF, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd0,    16'sh0000, 7'd0, 1'b1, 16'sh8000, STATUS_BELOW},
		'{ROW_CONVERT,     6'd0, 12'd4095, 16'sh0000, 7'd0, 1'b1, 16'sh7FFF, STATUS_ABOVE},
		'{ROW_CONVERT,     6'd0, 12'd100,  16'sh0000, 7'd0, 1'b1, 16'sh8000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd4000, 16'sh0000, 7'd0, 1'b1, 16'sh7FFF, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd2050, 16'sh0000, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_LOAD,        6'd2, 12'd4095, 16'sh0010, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_POINT_COUNT, 6'd0, 12'd0,    16'sh0000, 7'd3, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd4050, 16'sh0000, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd4095, 16'sh0000, 7'd0, 1'b1, 16'sh0010, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd50,   16'sh0000, 7'd0, 1'b1, 16'sh8000, STATUS_BELOW},
		'{ROW_CONVERT,     6'd0, 12'd4050, 16'sh0000, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_POINT_COUNT, 6'd0, 12'd0,    16'sh0000, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd4095, 16'sh0000, 7'd0, 1'b1, 16'sh7FFF, STATUS_ABOVE},
		'{ROW_POINT_COUNT, 6'd0, 12'd0,    16'sh0000, 7'd1, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd1000, 16'sh0000, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_LOAD,        6'd0, 12'd0,    16'sh0005, 7'd0, 1'b0, 16'sh0000, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd0,    16'sh0000, 7'd0, 1'b1, 16'sh0005, STATUS_INSIDE},
		'{ROW_CONVERT,     6'd0, 12'd4001, 16'sh0000, 7'd0, 1'b1, 16'sh7FFF, STATUS_ABOVE}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     cmd;
	logic [IDX_W-1:0]         point_index;
	logic [ADC_W-1:0]         adc_value;
	logic signed [TEMP_W-1:0] point_temperature;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [TEMP_W-1:0] temperature;
	logic [STATUS_W-1:0]      range_status;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [PIU_W-1:0]         points_in_use;

	logic [ADC_W-1:0]         table_reading [DEPTH];
	logic signed [TEMP_W-1:0] table_temp [DEPTH];
	bit                       loaded [DEPTH];
	logic [IDX_W-1:0]         cached_segment;
	logic [PIU_W-1:0]         point_count;

	conversion_t pending_conversions [$];
	int          accepted_items = 0;
	int          errors = 0;
	int          cycle_count = 0;
	bit          hold_request = 1'b0;
	bit          hold_active = 1'b0;

	piecewise_linear_table_interpolator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cmd               (cmd),
		.point_index       (point_index),
		.adc_value         (adc_value),
		.point_temperature (point_temperature),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature       (temperature),
		.range_status      (range_status),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.points_in_use     (points_in_use)
	);

	always #2 clk = ~clk;

	function automatic int active_points();
		int n;
		n = point_count;
		if (n < 2) n = 2;
		if (n > DEPTH) n = DEPTH;
		return n;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Walks the cached segment to the reading, then clamps, matches or interpolates.
	function automatic void convert_reading(input logic [ADC_W-1:0] x, output conversion_t res);
		int               n, lo, hi;
		logic [ADC_W-1:0] x0, x1;
		longint           y0, y1, num, den;
		n = active_points();
		lo = cached_segment;
		if (lo > n - 2) lo = n - 2;
		hi = lo + 1;
		x0 = table_reading[lo];
		x1 = table_reading[hi];
		res.status = STATUS_INSIDE;
		if (x0 > x) begin
			while (x0 > x) begin
				if (lo == 0) begin
					res.status = STATUS_BELOW;
					break;
				end
				lo--;
				hi--;
				x1 = x0;
				x0 = table_reading[lo];
			end
		end else if (x1 < x) begin
			while (x1 < x) begin
				if (hi == n - 1) begin
					res.status = STATUS_ABOVE;
					break;
				end
				lo++;
				hi++;
				x0 = x1;
				x1 = table_reading[hi];
			end
		end
		if (res.status == STATUS_BELOW) begin
			res.temp = table_temp[lo];
		end else if (res.status == STATUS_ABOVE || x == x1) begin
			res.temp = table_temp[hi];
		end else if (x == x0) begin
			res.temp = table_temp[lo];
		end else begin
			y0 = table_temp[lo];
			y1 = table_temp[hi];
			num = (longint'(x) - longint'(x0)) * (y1 - y0);
			den = longint'(x1) - longint'(x0);
			res.temp = TEMP_W'(y0 + num / den);
		end
		cached_segment = IDX_W'(lo);
	endfunction

	task automatic offer_request(input logic c, input logic [IDX_W-1:0] idx,
			input logic [ADC_W-1:0] x, input logic signed [TEMP_W-1:0] t,
			input bit known, input conversion_t typed_result);
		conversion_t res;
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		point_index <= idx;
		adc_value <= x;
		point_temperature <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (c == CMD_LOAD) begin
			table_reading[idx] = x;
			table_temp[idx] = t;
			loaded[idx] = 1'b1;
		end else begin
			convert_reading(x, res);
			pending_conversions.push_back(known ? typed_result : res);
		end
		accepted_items++;
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			cmd <= 1'($urandom);
			point_index <= IDX_W'($urandom);
			adc_value <= ADC_W'($urandom);
			point_temperature <= TEMP_W'($urandom);
		end
	endtask

	// The point count is only written once every conversion has come out.
	task automatic write_point_count(input logic [PIU_W-1:0] value);
		hold_off(1);
		while (pending_conversions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		points_in_use <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		point_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		points_in_use <= PIU_W'($urandom);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		conversion_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_conversions.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, temperature %0d status %0d",
					$time, temperature, range_status);
			end else begin
				want = pending_conversions.pop_front();
				if (temperature !== want.temp) begin
					errors++;
					$display("%0t: temperature expected %0d actual %0d",
						$time, want.temp, temperature);
				end
				if (range_status !== want.status) begin
					errors++;
					$display("%0t: range_status expected %0d actual %0d",
						$time, want.status, range_status);
				end
			end
		end
	end

	initial begin
		int free_run, stall_run;
		out_stall = 1'b0;
		forever begin
			free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
			repeat (free_run) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				stall_run = LONG_HOLD;
			end else begin
				stall_run = pick_gap();
			end
			repeat (stall_run) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			hold_active = 1'b0;
		end
	end

	initial begin
		directed_row_t    row;
		int               eff, step, r, k, xi, phase;
		bit               burst, rising, ready;
		logic [PIU_W-1:0] count_value;
		logic [ADC_W-1:0] x;
		logic signed [TEMP_W-1:0] t;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_CONVERT;
		point_index = '0;
		adc_value = '0;
		point_temperature = '0;
		cfg_valid = 1'b0;
		points_in_use = '0;
		point_count = 7'd2;
		cached_segment = '0;
		foreach (loaded[i]) loaded[i] = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			case (row.kind)
				ROW_POINT_COUNT: write_point_count(row.count);
				ROW_LOAD: offer_request(CMD_LOAD, row.idx, row.reading, row.temp, 1'b0, '0);
				default: offer_request(CMD_CONVERT, '0, row.reading, '0, row.known,
					conversion_t'{row.exp_temp, row.exp_status});
			endcase
			if (row.kind != ROW_POINT_COUNT) hold_off(pick_gap());
		end

		phase = 0;
		while (accepted_items < ITEM_TARGET) begin
			if (phase == 2) begin
				count_value = 7'd127;
			end else if (phase == 5) begin
				count_value = 7'd64;
			end else if (phase == 7) begin
				count_value = PIU_W'($urandom_range(0, 1));
			end else begin
				r = $urandom_range(0, 15);
				if (r == 0) count_value = PIU_W'($urandom_range(0, 1));
				else if (r == 1) count_value = PIU_W'($urandom_range(65, 127));
				else if (r == 2) count_value = 7'd64;
				else count_value = PIU_W'($urandom_range(2, 16));
			end
			write_point_count(count_value);
			eff = active_points();
			burst = (phase == 1) || ($urandom_range(0, 3) == 0);

			ready = 1'b1;
			for (int i = 0; i < eff; i++) if (!loaded[i]) ready = 1'b0;
			if (!ready || $urandom_range(0, 1) == 1) begin
				rising = ($urandom_range(0, 5) != 0);
				step = (ADC_MAX + 1) / eff;
				for (int i = 0; i < eff; i++) begin
					if (rising) x = ADC_W'(i * step + $urandom_range(0, step - 1));
					else x = ADC_W'($urandom);
					if (i == 0 && $urandom_range(0, 3) == 0) x = '0;
					if (i == eff - 1 && rising && $urandom_range(0, 3) == 0) x = ADC_W'(ADC_MAX);
					t = TEMP_W'($urandom);
					if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
					offer_request(CMD_LOAD, IDX_W'(i), x, t, 1'b0, '0);
					hold_off(burst ? 0 : pick_gap());
				end
			end

			// The receiver holds off for a long stretch while requests keep coming.
			if (phase == 1) begin
				hold_request = 1'b1;
				wait (hold_active);
			end

			repeat ($urandom_range(15, 35)) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					offer_request(CMD_LOAD, IDX_W'($urandom), ADC_W'($urandom),
						TEMP_W'($urandom), 1'b0, '0);
				end else begin
					if (r < 45) begin
						xi = $urandom_range(0, ADC_MAX);
					end else if (r < 85) begin
						k = $urandom_range(0, eff - 1);
						xi = table_reading[k];
						case ($urandom_range(0, 2))
							0: if (xi > 0) xi--;
							2: if (xi < ADC_MAX) xi++;
							default: ;
						endcase
					end else begin
						xi = $urandom_range(0, 1) ? ADC_MAX : 0;
					end
					offer_request(CMD_CONVERT, IDX_W'($urandom), ADC_W'(xi),
						TEMP_W'($urandom), 1'b0, '0);
				end
				hold_off(burst ? 0 : pick_gap());
			end
			phase++;
		end

		hold_off(1);
		while (pending_conversions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_conversions.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
